[rtl/lcbq_pkg.sv]
package lcbq_pkg;

    // Default configuration of the quantiser.
    localparam int NUM_BANDS_DEF        = 32;
    localparam int SAMPLE_FRAC_BITS_DEF = 16;

    // Fixed widths of the datapath.
    localparam int SAMPLE_W = 18;
    localparam int BAND_W   = 5;
    localparam int CODE_W   = 16;
    localparam int X_W      = 17;   // Q0.16 magnitude, 0 to 65536
    localparam int LOG_W    = 17;   // Q0.16 log value, 0 to 65536
    localparam int STEP_W   = 15;
    localparam int DIFF_W   = 11;   // largest step between log table entries
    localparam int FRAC_W   = 10;   // interpolation fraction
    localparam int SEG_W    = 7;    // segment index, 64 means exactly 1.0
    localparam int P_W      = 31;   // L * step + 5.0
    localparam int PROD_W   = X_W + P_W;

    localparam int LOG_ENTRIES = 65;
    localparam int LATENCY     = 6;

    localparam logic [CODE_W:0] CODE_MAX = 17'd32767;

    // Per-band step values, indexed by band.
    localparam logic [STEP_W-1:0] STEP_ROM [0:31] = '{
        15'd32760, 15'd32760, 15'd26150, 15'd22283, 15'd19540, 15'd17412, 15'd15673,
        15'd14203, 15'd12930, 15'd11806, 15'd10802, 15'd9893,  15'd9063,  15'd8300,
        15'd7593,  15'd6935,  15'd6320,  15'd5741,  15'd5196,  15'd4681,  15'd4192,
        15'd3726,  15'd3283,  15'd2859,  15'd2453,  15'd2064,  15'd1690,  15'd1330,
        15'd983,   15'd648,   15'd325,   15'd12
    };

    typedef logic [LOG_W-1:0] t_log_tab [0:LOG_ENTRIES-1];

    // Builds log2(1 + i/64) in Q0.16 by repeated squaring in Q2.30, taking
    // twenty fraction bits and rounding them to sixteen. Evaluated once at
    // elaboration to give a constant table.
    function automatic t_log_tab f_build_log_tab();
        t_log_tab   tab;
        logic [63:0] y;
        logic [31:0] r;
        for (int i = 0; i < LOG_ENTRIES - 1; i++) begin
            y = 64'(64 + i) << 24;
            r = '0;
            for (int k = 0; k < 20; k++) begin
                y = (y * y) >> 30;
                r = r << 1;
                if (y >= (64'd2 << 30)) begin
                    r = r | 32'd1;
                    y = y >> 1;
                end
            end
            tab[i] = LOG_W'((r + 32'd8) >> 4);
        end
        tab[LOG_ENTRIES-1] = LOG_W'(65536);
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = f_build_log_tab();

    // Beat leaving the front stage.
    typedef struct packed {
        logic              neg;
        logic [X_W-1:0]    x;
        logic [BAND_W-1:0] band;
    } t_front;

    // Beat leaving the log lookup and interpolation stages.
    typedef struct packed {
        logic              neg;
        logic [X_W-1:0]    x;
        logic [STEP_W-1:0] step;
        logic [LOG_W-1:0]  l;
    } t_lookup;

endpackage

[rtl/lcbq_front.sv]
module lcbq_front
    import lcbq_pkg::*;
#(
    parameter int NUM_BANDS        = NUM_BANDS_DEF,
    parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [BAND_W-1:0]   i_band,
    output logic                       o_valid,
    output t_front                     o_data
);

    // Magnitude width wide enough to hold 1.0 in the sample format.
    localparam int MAG_W = (SAMPLE_FRAC_BITS + 1 > SAMPLE_W) ? SAMPLE_FRAC_BITS + 1 : SAMPLE_W;
    localparam logic [MAG_W-1:0]  ONE      = MAG_W'(1) << SAMPLE_FRAC_BITS;
    localparam int                SHIFT    = SAMPLE_FRAC_BITS - 12;
    localparam logic [BAND_W-1:0] BAND_TOP = BAND_W'(NUM_BANDS - 1);

    logic                r_valid;
    t_front              r_data;
    t_front              n_data;
    logic [SAMPLE_W-1:0] mag;
    logic [MAG_W-1:0]    mag_sat;
    logic [MAG_W+3:0]    x_wide;

    // Magnitude, saturation to 1.0 and conversion to Q0.16. The most
    // negative sample negates to itself, which already reads as 2.0.
    always_comb begin
        n_data.neg = i_sample[SAMPLE_W-1];
        mag        = n_data.neg ? (~i_sample + 1'b1) : i_sample;
        mag_sat    = (MAG_W'(mag) > ONE) ? ONE : MAG_W'(mag);
        x_wide     = {mag_sat, 4'b0000} >> SHIFT;
        n_data.x   = X_W'(x_wide);
        n_data.band = (i_band > BAND_TOP) ? BAND_TOP : i_band;
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/lcbq_lookup.sv]
module lcbq_lookup
    import lcbq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_front  i_data,
    output logic    o_valid,
    output t_lookup o_data
);

    logic [SEG_W-1:0]  seg;
    logic [SEG_W-1:0]  idx_lo;
    logic [SEG_W-1:0]  idx_hi;

    // Table read stage.
    logic              r_tab_valid;
    logic              r_neg;
    logic [X_W-1:0]    r_x;
    logic [STEP_W-1:0] r_step;
    logic [LOG_W-1:0]  r_a;
    logic [DIFF_W-1:0] r_d;
    logic [FRAC_W-1:0] r_f;
    logic [LOG_W-1:0]  n_a;
    logic [DIFF_W-1:0] n_d;

    // Interpolation stage.
    logic               r_valid;
    t_lookup            r_data;
    t_lookup            n_data;
    logic [DIFF_W+FRAC_W:0] interp;

    // Segment selection; exactly 1.0 lands on the last entry with no slope.
    always_comb begin
        seg    = i_data.x[X_W-1:FRAC_W];
        idx_lo = {1'b0, seg[SEG_W-2:0]};
        idx_hi = idx_lo + 1'b1;
        if (seg[SEG_W-1]) begin
            n_a = LOG_TAB[LOG_ENTRIES-1];
            n_d = '0;
        end else begin
            n_a = LOG_TAB[idx_lo];
            n_d = DIFF_W'(LOG_TAB[idx_hi] - LOG_TAB[idx_lo]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= i_data.neg;
        r_x    <= i_data.x;
        r_step <= STEP_ROM[i_data.band];
        r_a    <= n_a;
        r_d    <= n_d;
        r_f    <= i_data.x[FRAC_W-1:0];
    end

    // Linear interpolation between neighbouring entries, rounded half up.
    always_comb begin
        interp      = (DIFF_W+FRAC_W+1)'(r_d) * (DIFF_W+FRAC_W+1)'(r_f)
                    + (DIFF_W+FRAC_W+1)'(512);
        n_data.neg  = r_neg;
        n_data.x    = r_x;
        n_data.step = r_step;
        n_data.l    = r_a + LOG_W'(interp >> FRAC_W);
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_tab_valid <= i_valid;
            r_valid     <= r_tab_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/lcbq_scale.sv]
module lcbq_scale
    import lcbq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_lookup                  i_data,
    output logic                     o_valid,
    output logic signed [CODE_W-1:0] o_code
);

    // Gain stage.
    logic              r_p_valid;
    logic              r_p_neg;
    logic [X_W-1:0]    r_p_x;
    logic [P_W-1:0]    r_p;

    // Product stage.
    logic              r_m_valid;
    logic              r_m_neg;
    logic [PROD_W-1:0] r_prod;

    // Output stage.
    logic                     r_valid;
    logic signed [CODE_W-1:0] r_code;
    logic signed [CODE_W-1:0] n_code;
    logic [PROD_W:0]          rounded;
    logic [CODE_W:0]          mag;
    logic [CODE_W:0]          mag_sat;

    // Gain is L * step plus 5.0 in Q0.16.
    always_ff @(posedge i_clk) begin
        r_p_neg <= i_data.neg;
        r_p_x   <= i_data.x;
        r_p     <= P_W'(i_data.l) * P_W'(i_data.step) + P_W'(5 << 16);
    end

    // Full product of magnitude and gain.
    always_ff @(posedge i_clk) begin
        r_m_neg <= r_p_neg;
        r_prod  <= PROD_W'(r_p_x) * PROD_W'(r_p);
    end

    // Round at bit 32, clamp and restore the sign.
    always_comb begin
        rounded = {1'b0, r_prod} + ((PROD_W+1)'(1) << 31);
        mag     = rounded[PROD_W:32];
        mag_sat = (mag > CODE_MAX) ? CODE_MAX : mag;
        n_code  = r_m_neg ? -$signed(CODE_W'(mag_sat)) : $signed(CODE_W'(mag_sat));
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
            r_m_valid <= r_p_valid;
            r_valid   <= r_m_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;

endmodule

[rtl/log_companding_band_quantizer_unit.sv]
// Throughput: one beat per cycle; six register stages, the widest being the
// 17 x 31 bit product of magnitude and gain.
// busy stays low, since the receiver cannot stall and no stage ever waits.
// Reset (synchronous, active low) clears every valid bit; nothing is in flight after it.
module log_companding_band_quantizer_unit
    import lcbq_pkg::*;
#(
    parameter int NUM_BANDS        = NUM_BANDS_DEF,
    parameter int SAMPLE_FRAC_BITS = SAMPLE_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [BAND_W-1:0]   i_band,
    output logic                       o_valid,
    output logic signed [CODE_W-1:0]   o_code
);

    logic    accept;
    logic    front_valid;
    t_front  front_data;
    logic    lookup_valid;
    t_lookup lookup_data;

    // The pipeline never holds a beat back.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Magnitude, saturation and band clamp.
    lcbq_front #(
        .NUM_BANDS        (NUM_BANDS),
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_sample (i_sample),
        .i_band   (i_band),
        .o_valid  (front_valid),
        .o_data   (front_data)
    );

    // Log table read, step read and interpolation.
    lcbq_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_valid (lookup_valid),
        .o_data  (lookup_data)
    );

    // Gain, product, rounding and sign.
    lcbq_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lookup_valid),
        .i_data  (lookup_data),
        .o_valid (o_valid),
        .o_code  (o_code)
    );

`ifndef ASSERT_OFF
    // Every accepted beat comes out after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("accepted beat did not emerge after the pipeline latency");

    // The clamp keeps the code symmetric: the most negative value never appears.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_code != -16'sd32768))
        else $error("code outside the symmetric range");

    // A negative code only comes from a negative sample.
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_code[CODE_W-1]) |-> $past(i_sample[SAMPLE_W-1], LATENCY))
        else $error("negative code from a non-negative sample");

    // A zero sample always gives a zero code.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_sample == '0)) |-> ##LATENCY (o_code == '0))
        else $error("zero sample gave a non-zero code");
`endif

endmodule

[tb/log_companding_band_quantizer_unit_tb.sv]
`timescale 1ns / 100ps

module log_companding_band_quantizer_unit_tb;
    import lcbq_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOWN_ERRORS = 10;

    // Step value per band, as held in the quantiser's ROM.
    localparam int unsigned BAND_STEP [0:31] = '{
        32760, 32760, 26150, 22283, 19540, 17412, 15673, 14203,
        12930, 11806, 10802,  9893,  9063,  8300,  7593,  6935,
         6320,  5741,  5196,  4681,  4192,  3726,  3283,  2859,
         2453,  2064,  1690,  1330,   983,   648,   325,    12
    };

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic        [BAND_W-1:0]   bnd;
    } t_sample_beat;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic        [BAND_W-1:0]   bnd;
        logic signed [CODE_W-1:0]   code;
    } t_code_beat;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic        [BAND_W-1:0]   i_band = '0;
    logic                       o_valid;
    logic signed [CODE_W-1:0]   o_code;

    t_sample_beat sample_queue [$];
    t_code_beat   pending_codes [$];
    int unsigned  log2_tab [0:64];
    logic         beat_taken = 1'b0;
    int           idle_left = 0;
    int           steady_left = 0;
    int           fail_count = 0;
    int           shown_count = 0;
    int           cycle_count = 0;

    log_companding_band_quantizer_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_sample (i_sample),
        .i_band   (i_band),
        .o_valid  (o_valid),
        .o_code   (o_code)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // One entry of log2(1 + idx/64) in Q0.16, found bit by bit through
    // repeated squaring of the Q2.30 argument.
    function automatic int unsigned log2_entry(int unsigned idx);
        bit [63:0]   acc;
        int unsigned bits_out;
        if (idx >= 64) begin
            return 65536;
        end
        acc = 64'(64 + idx) << 24;
        bits_out = 0;
        for (int k = 0; k < 20; k++) begin
            acc = (acc * acc) >> 30;
            bits_out = bits_out << 1;
            if (acc >= 64'h8000_0000) begin
                bits_out = bits_out | 1;
                acc = acc >> 1;
            end
        end
        return (bits_out + 8) >> 4;
    endfunction

    // Quantiser code for one sample and band.
    function automatic logic signed [CODE_W-1:0] quantised_code(
        logic signed [SAMPLE_W-1:0] smp,
        logic        [BAND_W-1:0]   bnd
    );
        longint            mag;
        longint unsigned   x;
        longint unsigned   seg;
        longint unsigned   frac;
        longint unsigned   lv;
        longint unsigned   gain;
        longint unsigned   mag_code;
        int unsigned       b;
        logic [CODE_W-1:0] bits;
        mag = smp[SAMPLE_W-1] ? -longint'(smp) : longint'(smp);
        if (mag > (longint'(1) << SAMPLE_FRAC_BITS_DEF)) begin
            mag = longint'(1) << SAMPLE_FRAC_BITS_DEF;
        end
        if (SAMPLE_FRAC_BITS_DEF >= 16) begin
            x = longint'(mag) >> (SAMPLE_FRAC_BITS_DEF - 16);
        end else begin
            x = longint'(mag) << (16 - SAMPLE_FRAC_BITS_DEF);
        end
        b = (int'(bnd) > NUM_BANDS_DEF - 1) ? NUM_BANDS_DEF - 1 : int'(bnd);
        if (x == 0) begin
            return '0;
        end
        // Interpolate between neighbouring log table entries.
        seg = x >> 10;
        frac = x & 1023;
        if (seg >= 64) begin
            lv = 65536;
        end else begin
            lv = log2_tab[seg] +
                 (((longint'(log2_tab[seg + 1]) - log2_tab[seg]) * frac + 512) >> 10);
        end
        gain = lv * BAND_STEP[b] + (longint'(5) << 16);
        mag_code = (x * gain + 64'h8000_0000) >> 32;
        if (mag_code > 32767) begin
            mag_code = 32767;
        end
        bits = CODE_W'(mag_code);
        return smp[SAMPLE_W-1] ? -bits : bits;
    endfunction

    // Idle cycles after a beat: mostly none or few, now and then a long gap,
    // and occasional stretches with no idling at all.
    function automatic int next_gap();
        int roll;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            steady_left = $urandom_range(20, 80);
            return 0;
        end else if (roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Random sample with weight on the interesting regions.
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int roll;
        int mag;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return SAMPLE_W'(int'($urandom_range(0, 131072)) - 65536);
        end else if (roll < 60) begin
            mag = $urandom_range(0, 2047);
        end else if (roll < 75) begin
            mag = int'($urandom_range(0, 64)) * 1024 + int'($urandom_range(0, 6)) - 3;
            if (mag < 0) begin
                mag = 0;
            end
        end else begin
            return SAMPLE_W'($urandom);
        end
        return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    task automatic add_item(int smp, int bnd);
        t_sample_beat item;
        item.smp = SAMPLE_W'(smp);
        item.bnd = BAND_W'(bnd);
        sample_queue.push_back(item);
    endtask

    // Driver: presents beats at the falling edge and moves on once taken.
    always @(negedge i_clk) begin : drive
        t_sample_beat item;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
                i_sample <= SAMPLE_W'($urandom);
                i_band <= BAND_W'($urandom);
            end else if (sample_queue.size() > 0) begin
                item = sample_queue.pop_front();
                i_sample <= item.smp;
                i_band <= item.bnd;
                start <= 1'b1;
                idle_left = next_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks codes against the oldest prediction and records
    // accepted beats.
    always @(posedge i_clk) begin : watch
        t_code_beat want;
        t_code_beat got;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_codes.size() == 0) begin
                fail_count++;
                if (shown_count < SHOWN_ERRORS) begin
                    shown_count++;
                    $display("Unexpected code %0d with nothing outstanding", o_code);
                end
            end else begin
                want = pending_codes.pop_front();
                if (o_code !== want.code) begin
                    fail_count++;
                    if (shown_count < SHOWN_ERRORS) begin
                        shown_count++;
                        $display("Code mismatch: sample %0d band %0d expected %0d got %0d",
                                 want.smp, want.bnd, want.code, o_code);
                    end
                end
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            got.smp = i_sample;
            got.bnd = i_band;
            got.code = quantised_code(i_sample, i_band);
            pending_codes.push_back(got);
        end
        beat_taken <= i_rst_n && start && busy === 1'b0;
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 65; i++) begin
            log2_tab[i] = log2_entry(i);
        end

        // Directed beats: zero, extremes, saturation, sign and segment edges.
        add_item(0, 0);
        add_item(1, 0);
        add_item(-1, 0);
        add_item(65536, 0);
        add_item(-65536, 0);
        add_item(65535, 1);
        add_item(131071, 31);
        add_item(-131072, 31);
        add_item(-131071, 5);
        add_item(65537, 2);
        add_item(1023, 3);
        add_item(1024, 4);
        add_item(1025, 30);
        add_item(-1024, 29);
        add_item(32768, 15);
        add_item(-32768, 16);
        add_item(64512, 7);
        add_item(64511, 8);
        add_item(2, 31);
        add_item(-2, 31);
        add_item(100000, 12);
        add_item(0, 31);
        add_item(-65535, 0);

        // Random beats over all bands.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            add_item(int'(random_sample()), $urandom_range(0, 31));
        end

        // Hold reset, then release it at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the queue to drain and every code to arrive.
        while (sample_queue.size() != 0 || start || pending_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        if (fail_count == 0 && pending_codes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lcbq_pkg.sv
rtl/lcbq_front.sv
rtl/lcbq_lookup.sv
rtl/lcbq_scale.sv
rtl/log_companding_band_quantizer_unit.sv
tb/log_companding_band_quantizer_unit_tb.sv
